@@ rtl/core/uwt_pkg.sv @@
`default_nettype none

package uwt_pkg;

    // Result codes
    typedef enum logic [2:0] {
        KIND_TOKEN_BYTE = 3'd0,
        KIND_TOKEN_END  = 3'd1,
        KIND_INVALID    = 3'd2,
        KIND_EMPTY      = 3'd3,
        KIND_TEXT_END   = 3'd4
    } kind_t;

    // Configuration register indexes
    localparam logic CFG_KEEP_DIGITS = 1'b0;
    localparam logic CFG_FOLD_YO     = 1'b1;

    localparam int CP_W      = 21;
    localparam int IDX_W     = 24;
    localparam int BATCH_MAX = 4;     // most results one request can cause

    localparam logic [IDX_W-1:0] TOKEN_MAX = {IDX_W{1'b1}};

    // Code points
    localparam logic [CP_W-1:0] CP_CYR_UP_LO  = 21'h000410;
    localparam logic [CP_W-1:0] CP_CYR_UP_HI  = 21'h00042F;
    localparam logic [CP_W-1:0] CP_YO_UP      = 21'h000401;
    localparam logic [CP_W-1:0] CP_YO_LO      = 21'h000451;
    localparam logic [CP_W-1:0] CP_YE_LO      = 21'h000435;
    localparam logic [CP_W-1:0] CP_YE_UP      = 21'h000415;
    localparam logic [CP_W-1:0] CP_GRK_UP_LO  = 21'h000391;
    localparam logic [CP_W-1:0] CP_GRK_UP_HI  = 21'h0003A9;
    localparam logic [CP_W-1:0] CP_LAT_EXT_LO = 21'h0000C0;
    localparam logic [CP_W-1:0] CP_LAT_EXT_HI = 21'h00024F;
    localparam logic [CP_W-1:0] CP_GRK_LO     = 21'h000370;
    localparam logic [CP_W-1:0] CP_GRK_HI     = 21'h0003FF;
    localparam logic [CP_W-1:0] CP_CYR_LO     = 21'h000400;
    localparam logic [CP_W-1:0] CP_CYR_HI     = 21'h0004FF;
    localparam logic [CP_W-1:0] CP_ASCII_A    = 21'h000041;
    localparam logic [CP_W-1:0] CP_ASCII_Z    = 21'h00005A;
    localparam logic [CP_W-1:0] CP_ASCII_LA   = 21'h000061;
    localparam logic [CP_W-1:0] CP_ASCII_LZ   = 21'h00007A;
    localparam logic [CP_W-1:0] CP_DIGIT_0    = 21'h000030;
    localparam logic [CP_W-1:0] CP_DIGIT_9    = 21'h000039;
    localparam logic [CP_W-1:0] CP_ASCII_TOP  = 21'h00007F;
    localparam logic [CP_W-1:0] CP_CASE_STEP  = 21'h000020;

    // One result as it sits in the output batch
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data;
        logic [IDX_W-1:0]  idx;
    } result_t;

    function automatic logic cp_is_letter(input logic [CP_W-1:0] cp);
        return (cp inside {[CP_CYR_LO:CP_CYR_HI], [CP_ASCII_A:CP_ASCII_Z],
                           [CP_ASCII_LA:CP_ASCII_LZ], [CP_LAT_EXT_LO:CP_LAT_EXT_HI],
                           [CP_GRK_LO:CP_GRK_HI]});
    endfunction

    function automatic logic [CP_W-1:0] lower_cp(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] res;
        res = cp;
        if (cp inside {[CP_CYR_UP_LO:CP_CYR_UP_HI], [CP_ASCII_A:CP_ASCII_Z],
                       [CP_GRK_UP_LO:CP_GRK_UP_HI]})
        begin
            res = cp + CP_CASE_STEP;
        end
        else if (cp == CP_YO_UP)
        begin
            res = CP_YO_LO;
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] v);
        return (v == TOKEN_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/utf8_word_tokenizer_unit.sv @@
// Channel   Handshake              Payload
// input     in_valid / in_ready    data_byte, has_byte, end_of_text
// output    out_valid / out_ready  kind, out_byte, token_index, last_of_run
// config    cfg_write              cfg_index, cfg_data (no wait, no read-back)
//
// One request per cycle while each gives at most one result and out_ready is
// high; a request giving several results keeps the output busy, and the next
// request waits in the input register until the last of them is taken.
// The first result passes the input register and then the result batch
// register before it shows at the output.
// The input register takes a request while a result still waits at the output.
// Reset clears the text state and sets both configuration bits.
`default_nettype none

module utf8_word_tokenizer_unit
    import uwt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic              cfg_data,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              has_byte,
    input  wire logic              end_of_text,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             kind,
    output logic [7:0]             out_byte,
    output logic [IDX_W-1:0]       token_index,
    output logic                   last_of_run
);

    localparam int PTR_W  = $clog2(BATCH_MAX);
    localparam int LEFT_W = $clog2(BATCH_MAX + 1);

    // configuration
    logic keep_digits_reg;
    logic fold_yo_reg;

    // input register
    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_has_reg;
    logic       hold_fin_reg;

    // text state
    logic [CP_W-1:0]  acc_reg,   acc_next;
    logic [1:0]       pend_reg,  pend_next;
    logic             open_reg,  open_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             seen_reg,  seen_next;
    logic             err_reg,   err_next;

    // result batch
    result_t           batch_reg [BATCH_MAX];
    result_t           batch_next [BATCH_MAX];
    logic [LEFT_W-1:0] left_reg;
    logic [LEFT_W-1:0] num_next;
    logic [PTR_W-1:0]  rd_ptr_reg;

    logic in_fire;
    logic out_fire;
    logic advance;

    // decode scratch
    logic            cp_done;
    logic            bad;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] cp_fold;
    logic [CP_W-1:0] cp_low;
    logic [CP_W-1:0] acc_shift;
    logic            keep;

    // handshakes
    assign out_valid = (left_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign advance   = hold_valid_reg &&
                       ((left_reg == '0) || ((left_reg == LEFT_W'(1)) && out_ready));
    assign in_ready  = !hold_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;

    // output port from the batch head
    assign kind        = batch_reg[rd_ptr_reg].kind;
    assign out_byte    = batch_reg[rd_ptr_reg].data;
    assign token_index = batch_reg[rd_ptr_reg].idx;
    assign last_of_run = (left_reg == LEFT_W'(1));

    // decode one request and build its results
    always_comb
    begin
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        open_next  = open_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        num_next   = '0;
        for (int i = 0; i < BATCH_MAX; i++)
        begin
            batch_next[i] = '{kind: KIND_TOKEN_BYTE, data: 8'h00, idx: '0};
        end
        cp_done   = 1'b0;
        bad       = 1'b0;
        cp        = '0;
        acc_shift = {acc_reg[CP_W-7:0], hold_byte_reg[5:0]};

        // UTF-8 byte
        if (hold_has_reg)
        begin
            seen_next = 1'b1;
            if (!err_reg)
            begin
                if (pend_reg == 2'd0)
                begin
                    if (!hold_byte_reg[7])
                    begin
                        cp_done = 1'b1;
                        cp      = {{(CP_W-8){1'b0}}, hold_byte_reg};
                    end
                    else if (hold_byte_reg[7:5] == 3'b110)
                    begin
                        acc_next  = {{(CP_W-5){1'b0}}, hold_byte_reg[4:0]};
                        pend_next = 2'd1;
                    end
                    else if (hold_byte_reg[7:4] == 4'b1110)
                    begin
                        acc_next  = {{(CP_W-4){1'b0}}, hold_byte_reg[3:0]};
                        pend_next = 2'd2;
                    end
                    else if (hold_byte_reg[7:3] == 5'b11110)
                    begin
                        acc_next  = {{(CP_W-3){1'b0}}, hold_byte_reg[2:0]};
                        pend_next = 2'd3;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                else if (hold_byte_reg[7:6] != 2'b10)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    pend_next = pend_reg - 2'd1;
                    if (pend_reg == 2'd1)
                    begin
                        cp_done  = 1'b1;
                        cp       = acc_shift;
                        acc_next = '0;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                    end
                end
            end
        end

        // bad lead or continuation byte
        if (bad)
        begin
            batch_next[num_next[PTR_W-1:0]] = '{kind: KIND_INVALID, data: 8'h00,
                                                idx: count_reg};
            num_next  = num_next + 1'b1;
            err_next  = 1'b1;
            open_next = 1'b0;
            pend_next = 2'd0;
            acc_next  = '0;
        end

        // complete code point: fold, lower-case, re-encode, or end the open token
        cp_fold = cp;
        if (fold_yo_reg && (cp == CP_YO_LO))
        begin
            cp_fold = CP_YE_LO;
        end
        else if (fold_yo_reg && (cp == CP_YO_UP))
        begin
            cp_fold = CP_YE_UP;
        end
        cp_low = cp_is_letter(cp) ? lower_cp(cp_fold) : cp;
        keep   = cp_is_letter(cp) ||
                 (keep_digits_reg && (cp >= CP_DIGIT_0) && (cp <= CP_DIGIT_9));

        if (cp_done)
        begin
            if (keep)
            begin
                if (cp_low <= CP_ASCII_TOP)
                begin
                    batch_next[num_next[PTR_W-1:0]] = '{kind: KIND_TOKEN_BYTE,
                                                        data: cp_low[7:0],
                                                        idx: count_reg};
                    num_next = num_next + 1'b1;
                end
                else
                begin
                    batch_next[num_next[PTR_W-1:0]] = '{kind: KIND_TOKEN_BYTE,
                                                        data: {3'b110, cp_low[10:6]},
                                                        idx: count_reg};
                    batch_next[num_next[PTR_W-1:0] + 1'b1] = '{kind: KIND_TOKEN_BYTE,
                                                        data: {2'b10, cp_low[5:0]},
                                                        idx: count_reg};
                    num_next = num_next + LEFT_W'(2);
                end
                open_next = 1'b1;
            end
            else if (open_reg)
            begin
                batch_next[num_next[PTR_W-1:0]] = '{kind: KIND_TOKEN_END, data: 8'h00,
                                                    idx: count_reg};
                num_next   = num_next + 1'b1;
                count_next = sat_inc(count_reg);
                open_next  = 1'b0;
            end
        end

        // end of text
        if (hold_fin_reg)
        begin
            if (!seen_next)
            begin
                batch_next[num_next[PTR_W-1:0]] = '{kind: KIND_EMPTY, data: 8'h00,
                                                    idx: '0};
                num_next = num_next + 1'b1;
            end
            else
            begin
                if (!err_next && (pend_next != 2'd0))
                begin
                    batch_next[num_next[PTR_W-1:0]] = '{kind: KIND_INVALID,
                                                        data: 8'h00, idx: count_next};
                    num_next = num_next + 1'b1;
                end
                else if (!err_next && open_next)
                begin
                    batch_next[num_next[PTR_W-1:0]] = '{kind: KIND_TOKEN_END,
                                                        data: 8'h00, idx: count_next};
                    num_next   = num_next + 1'b1;
                    count_next = sat_inc(count_next);
                end
                batch_next[num_next[PTR_W-1:0]] = '{kind: KIND_TEXT_END, data: 8'h00,
                                                    idx: count_next};
                num_next = num_next + 1'b1;
            end
            acc_next   = '0;
            pend_next  = 2'd0;
            open_next  = 1'b0;
            count_next = '0;
            seen_next  = 1'b0;
            err_next   = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_digits_reg <= 1'b1;
            fold_yo_reg     <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEEP_DIGITS: keep_digits_reg <= cfg_data;
                CFG_FOLD_YO:     fold_yo_reg     <= cfg_data;
                default:         keep_digits_reg <= keep_digits_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_byte_reg <= data_byte;
            hold_has_reg  <= has_byte;
            hold_fin_reg  <= end_of_text;
        end
    end

    // text state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            pend_reg  <= 2'd0;
            open_reg  <= 1'b0;
            count_reg <= '0;
            seen_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            open_reg  <= open_next;
            count_reg <= count_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
        end
    end

    // batch count and read pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            rd_ptr_reg <= '0;
        end
        else if (advance)
        begin
            left_reg   <= num_next;
            rd_ptr_reg <= '0;
        end
        else if (out_fire)
        begin
            left_reg   <= left_reg - 1'b1;
            rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // batch payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < BATCH_MAX; i++)
            begin
                batch_reg[i] <= batch_next[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/uwt_checker.sv @@
`default_nettype none

module uwt_checker
    import uwt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [2:0]        kind,
    input wire logic [7:0]        out_byte,
    input wire logic [IDX_W-1:0]  token_index,
    input wire logic              last_of_run
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
                                    && $stable(token_index) && $stable(last_of_run))
        else $error("stalled result changed");

    // empty text is a lone result with index zero
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_EMPTY) |-> last_of_run && (token_index == '0))
        else $error("empty-text result malformed");

    // text end always closes the run
    a_text_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_TEXT_END) |-> last_of_run)
        else $error("text end not last of run");

    // only token bytes carry data
    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_TOKEN_BYTE) |-> (out_byte == 8'h00))
        else $error("data on a non-byte result");

endmodule

bind utf8_word_tokenizer_unit uwt_checker u_uwt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .out_byte    (out_byte),
    .token_index (token_index),
    .last_of_run (last_of_run)
);

`default_nettype wire
